@@ rtl/cnsp_pkg.sv @@
// Shared types, codes and lookup functions for the cpio newc stream parser.
// Used by every module of the block; no dependencies.
package cnsp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_HEX     = 3'd1,
        PH_NAME    = 3'd2,
        PH_NAMEPAD = 3'd3,
        PH_DATA    = 3'd4,
        PH_DATAPAD = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_NAME   = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_END    = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    // field numbers of the newc header that the records carry
    localparam logic [3:0] FLD_INO      = 4'd0;
    localparam logic [3:0] FLD_MODE     = 4'd1;
    localparam logic [3:0] FLD_UID      = 4'd2;
    localparam logic [3:0] FLD_GID      = 4'd3;
    localparam logic [3:0] FLD_MTIME    = 4'd5;
    localparam logic [3:0] FLD_FILESIZE = 4'd6;
    localparam logic [3:0] FLD_NAMESIZE = 4'd11;
    localparam logic [3:0] FLD_LAST     = 4'd12;

    localparam logic [2:0] MAGIC_LAST   = 3'd5;
    localparam logic [2:0] DIGIT_LAST   = 3'd7;
    localparam logic [3:0] TRAILER_LEN  = 4'd11;
    localparam int unsigned TDATA_W     = 280;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] file_index;
        logic [31:0] inode_number;
        logic [31:0] file_mode;
        logic [31:0] owner_uid;
        logic [31:0] owner_gid;
        logic [31:0] modify_time;
        logic [31:0] file_size;
        logic [31:0] name_size;
        logic [31:0] data_offset;
        logic [7:0]  byte_value;
        logic        last_of_run;
    } record_t;

    typedef struct packed {
        logic    push;
        record_t rec;
    } rec_push_t;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0, 3'd2, 3'd4: c = 8'h30;
            3'd1, 3'd3:       c = 8'h37;
            3'd5:             c = 8'h31;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:             c = 8'h54; // T
            4'd1:             c = 8'h52; // R
            4'd2:             c = 8'h41; // A
            4'd3:             c = 8'h49; // I
            4'd4:             c = 8'h4C; // L
            4'd5:             c = 8'h45; // E
            4'd6:             c = 8'h52; // R
            4'd7, 4'd8, 4'd9: c = 8'h21; // !
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, nibble}; both upper and lower case letters decode
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

@@ rtl/cpio_newc_stream_parser_core.sv @@
// cpio newc archive parser: one archive byte in on s_, header, name, data, end
// and error records out on m_. One byte is taken every cycle while the
// two-entry record queue has room; a record goes through the queue and the
// output register to m_, and only m_tready back-pressure slows the input.
// After an end or error record every further byte is taken and dropped until
// reset. Depends on cnsp_pkg, cnsp_front, cnsp_fifo and cnsp_back.
module cpio_newc_stream_parser_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] archive_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] file_index, [47:16] inode_number, [79:48] file_mode,
    // [111:80] owner_uid, [143:112] owner_gid, [175:144] modify_time,
    // [207:176] file_size, [239:208] name_size, [271:240] data_offset,
    // [279:272] byte_value
    output logic [cnsp_pkg::TDATA_W-1:0]    m_tdata,
    output logic [2:0]                      m_tuser,   // [2:0] kind
    output logic                            m_tlast    // last_of_run
);

    cnsp_pkg::rec_push_t rec_push;
    cnsp_pkg::record_t   q_head;
    logic                q_full;
    logic                q_not_empty;
    logic                q_pop;
    logic                s_fire;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;

    cnsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (s_fire),
        .byte_in   (s_tdata),
        .out_push  (rec_push)
    );

    cnsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (rec_push),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    cnsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ rtl/cnsp_front.sv @@
// Front end: takes archive bytes, tracks the parse phase and builds records.
// Depends on cnsp_pkg; feeds cnsp_fifo.
module cnsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_fire,
    input  logic [7:0]           byte_in,
    output cnsp_pkg::rec_push_t  out_push
);

    cnsp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  fn_reg, fn_next;
    logic [2:0]  dc_reg, dc_next;
    logic [27:0] acc_reg, acc_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] rem_reg, rem_next;
    logic        tmatch_reg, tmatch_next;
    logic [3:0]  npos_reg, npos_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        ns_ge11_reg, ns_ge11_next;

    logic [31:0] ino_reg, mode_reg, uid_reg, gid_reg, mtime_reg, fsize_reg, nsize_reg;
    logic [31:0] dofs_reg;

    logic [1:0]  nxt2;
    logic [4:0]  hex_d;
    logic [31:0] field_v;
    logic        field_wr;
    logic        tm_new;
    cnsp_pkg::phase_t fin_phase, data_phase, name_after_phase;
    cnsp_pkg::rec_push_t rp;

    assign nxt2    = off_reg[1:0] + 2'd1;
    assign hex_d   = cnsp_pkg::hex_value(byte_in);
    assign field_v = {acc_reg, hex_d[3:0]};
    assign tm_new  = tmatch_reg &
                     !(npos_reg < cnsp_pkg::TRAILER_LEN && byte_in != cnsp_pkg::trailer_char(npos_reg));

    // where an entry goes once its name or data is used up
    assign fin_phase        = (nxt2 != 2'd0) ? cnsp_pkg::PH_DATAPAD : cnsp_pkg::PH_MAGIC;
    assign data_phase       = (fsize_reg != 32'd0) ? cnsp_pkg::PH_DATA : fin_phase;
    assign name_after_phase = (nxt2 != 2'd0) ? cnsp_pkg::PH_NAMEPAD : data_phase;

    always_comb begin
        phase_next   = phase_reg;
        fn_next      = fn_reg;
        dc_next      = dc_reg;
        acc_next     = acc_reg;
        off_next     = off_reg;
        rem_next     = rem_reg;
        tmatch_next  = tmatch_reg;
        npos_next    = npos_reg;
        cnt_next     = cnt_reg;
        ns_ge11_next = ns_ge11_reg;
        field_wr     = 1'b0;
        rp           = '0;
        rp.rec.file_index = cnt_reg;

        if (byte_fire && phase_reg != cnsp_pkg::PH_DONE && phase_reg != cnsp_pkg::PH_ERROR) begin
            off_next = off_reg + 32'd1;
            unique case (phase_reg)
                cnsp_pkg::PH_MAGIC: begin
                    if (byte_in != cnsp_pkg::magic_char(dc_reg)) begin
                        phase_next  = cnsp_pkg::PH_ERROR;
                        rp.push     = 1'b1;
                        rp.rec.kind = cnsp_pkg::KIND_ERROR;
                    end else if (dc_reg == cnsp_pkg::MAGIC_LAST) begin
                        phase_next = cnsp_pkg::PH_HEX;
                        dc_next    = 3'd0;
                    end else begin
                        dc_next = dc_reg + 3'd1;
                    end
                end
                cnsp_pkg::PH_HEX: begin
                    if (!hex_d[4]) begin
                        phase_next  = cnsp_pkg::PH_ERROR;
                        rp.push     = 1'b1;
                        rp.rec.kind = cnsp_pkg::KIND_ERROR;
                    end else if (dc_reg != cnsp_pkg::DIGIT_LAST) begin
                        acc_next = field_v[27:0];
                        dc_next  = dc_reg + 3'd1;
                    end else begin
                        field_wr = 1'b1;
                        acc_next = '0;
                        dc_next  = 3'd0;
                        if (fn_reg != cnsp_pkg::FLD_LAST) begin
                            fn_next = fn_reg + 4'd1;
                        end else begin
                            fn_next                = 4'd0;
                            rp.push                = 1'b1;
                            rp.rec.kind            = cnsp_pkg::KIND_HEADER;
                            rp.rec.inode_number    = ino_reg;
                            rp.rec.file_mode       = mode_reg;
                            rp.rec.owner_uid       = uid_reg;
                            rp.rec.owner_gid       = gid_reg;
                            rp.rec.modify_time     = mtime_reg;
                            rp.rec.file_size       = fsize_reg;
                            rp.rec.name_size       = nsize_reg;
                            rp.rec.data_offset     = dofs_reg;
                            rp.rec.last_of_run     = (fsize_reg == 32'd0);
                            tmatch_next  = 1'b1;
                            npos_next    = 4'd0;
                            ns_ge11_next = (nsize_reg >= 32'd11);
                            if (nsize_reg != 32'd0) begin
                                phase_next = cnsp_pkg::PH_NAME;
                                rem_next   = nsize_reg;
                            end else begin
                                phase_next = name_after_phase;
                                rem_next   = fsize_reg;
                                if (nxt2 == 2'd0 && fsize_reg == 32'd0 && cnt_reg != 16'hFFFF) begin
                                    cnt_next = cnt_reg + 16'd1;
                                end
                            end
                        end
                    end
                end
                cnsp_pkg::PH_NAME: begin
                    rem_next    = rem_reg - 32'd1;
                    tmatch_next = tm_new;
                    if (npos_reg < cnsp_pkg::TRAILER_LEN) begin
                        npos_next = npos_reg + 4'd1;
                    end
                    rp.push = 1'b1;
                    if (rem_reg == 32'd1 && tm_new && ns_ge11_reg) begin
                        phase_next  = cnsp_pkg::PH_DONE;
                        rp.rec.kind = cnsp_pkg::KIND_END;
                    end else begin
                        rp.rec.kind       = cnsp_pkg::KIND_NAME;
                        rp.rec.byte_value = byte_in;
                        if (rem_reg == 32'd1) begin
                            rp.rec.last_of_run = 1'b1;
                            phase_next         = name_after_phase;
                            if (nxt2 == 2'd0) begin
                                rem_next = fsize_reg;
                                if (fsize_reg == 32'd0 && cnt_reg != 16'hFFFF) begin
                                    cnt_next = cnt_reg + 16'd1;
                                end
                            end
                        end
                    end
                end
                cnsp_pkg::PH_NAMEPAD: begin
                    if (nxt2 == 2'd0) begin
                        phase_next = data_phase;
                        rem_next   = fsize_reg;
                        if (fsize_reg == 32'd0 && cnt_reg != 16'hFFFF) begin
                            cnt_next = cnt_reg + 16'd1;
                        end
                    end
                end
                cnsp_pkg::PH_DATA: begin
                    rem_next          = rem_reg - 32'd1;
                    rp.push           = 1'b1;
                    rp.rec.kind       = cnsp_pkg::KIND_DATA;
                    rp.rec.byte_value = byte_in;
                    if (rem_reg == 32'd1) begin
                        rp.rec.last_of_run = 1'b1;
                        phase_next         = fin_phase;
                        if (cnt_reg != 16'hFFFF) begin
                            cnt_next = cnt_reg + 16'd1;
                        end
                    end
                end
                cnsp_pkg::PH_DATAPAD: begin
                    if (nxt2 == 2'd0) begin
                        phase_next = cnsp_pkg::PH_MAGIC;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= cnsp_pkg::PH_MAGIC;
            fn_reg      <= '0;
            dc_reg      <= '0;
            acc_reg     <= '0;
            off_reg     <= '0;
            rem_reg     <= '0;
            tmatch_reg  <= 1'b1;
            npos_reg    <= '0;
            cnt_reg     <= '0;
            ns_ge11_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            fn_reg      <= fn_next;
            dc_reg      <= dc_next;
            acc_reg     <= acc_next;
            off_reg     <= off_next;
            rem_reg     <= rem_next;
            tmatch_reg  <= tmatch_next;
            npos_reg    <= npos_next;
            cnt_reg     <= cnt_next;
            ns_ge11_reg <= ns_ge11_next;
        end
    end

    // header field store; only the fields that records carry are kept
    always_ff @(posedge aclk) begin
        if (field_wr) begin
            unique case (fn_reg)
                cnsp_pkg::FLD_INO:      ino_reg   <= field_v;
                cnsp_pkg::FLD_MODE:     mode_reg  <= field_v;
                cnsp_pkg::FLD_UID:      uid_reg   <= field_v;
                cnsp_pkg::FLD_GID:      gid_reg   <= field_v;
                cnsp_pkg::FLD_MTIME:    mtime_reg <= field_v;
                cnsp_pkg::FLD_FILESIZE: fsize_reg <= field_v;
                cnsp_pkg::FLD_NAMESIZE: nsize_reg <= field_v;
                default: ;
            endcase
        end
    end

    // header ends eight bytes after the first digit of the last field: align that
    // plus the name size, ahead of the header record
    always_ff @(posedge aclk) begin
        if (byte_fire && phase_reg == cnsp_pkg::PH_HEX && fn_reg == cnsp_pkg::FLD_LAST
            && dc_reg == 3'd0) begin
            dofs_reg <= (off_reg + nsize_reg + 32'd11) & ~32'd3;
        end
    end

    assign out_push = rp;

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == cnsp_pkg::PH_DONE || phase_reg == cnsp_pkg::PH_ERROR) |-> !rp.push)
        else $error("record built while halted");

    a_header_from_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        (rp.push && rp.rec.kind == cnsp_pkg::KIND_HEADER) |=> (phase_reg != cnsp_pkg::PH_HEX
         && phase_reg != cnsp_pkg::PH_MAGIC && fn_reg == 4'd0))
        else $error("header record did not leave the header phase");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (rp.push && rp.rec.kind == cnsp_pkg::KIND_ERROR) |=> phase_reg == cnsp_pkg::PH_ERROR)
        else $error("error record without halt");

endmodule

@@ rtl/cnsp_fifo.sv @@
// Two-entry record queue between the parser front end and the output stage.
// Depends on cnsp_pkg.
module cnsp_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cnsp_pkg::rec_push_t  in_push,
    output logic                 full,
    output logic                 not_empty,
    input  logic                 pop,
    output cnsp_pkg::record_t    head
);

    cnsp_pkg::record_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = in_push.push;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_push.rec;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_push.push |-> !full)
        else $error("record pushed into full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

@@ rtl/cnsp_back.sv @@
// Output stage: holds one record on the result stream until it is taken.
// Depends on cnsp_pkg; pulls from cnsp_fifo.
module cnsp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_not_empty,
    input  cnsp_pkg::record_t               q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cnsp_pkg::TDATA_W-1:0]    m_tdata,
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast
);

    logic              valid_reg, valid_next;
    cnsp_pkg::record_t out_reg;
    logic              load;

    // refill whenever the held transfer goes or nothing is held
    assign load       = q_not_empty && (!valid_reg || m_tready);
    assign q_pop      = load;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= q_head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_of_run;
    assign m_tdata  = {out_reg.byte_value, out_reg.data_offset, out_reg.name_size,
                       out_reg.file_size, out_reg.modify_time, out_reg.owner_gid,
                       out_reg.owner_uid, out_reg.file_mode, out_reg.inode_number,
                       out_reg.file_index};

endmodule

@@ sim/tb_cpio_newc_stream_parser_core.sv @@
// Testbench for cpio_newc_stream_parser_core: builds one newc archive, streams it in
// under random back-pressure and checks every record against a byte-level parser model.
// Depends on cnsp_pkg and the parser RTL.
module tb_cpio_newc_stream_parser_core;
    import cnsp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_MARK  = -1;
    localparam logic [47:0] MAGIC_TEXT = "070701";
    localparam logic [87:0] END_NAME   = {"TRAILER!!!", 8'h00};

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    cpio_newc_stream_parser_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // archive bytes still to send, with a drain mark between the second and third entries
    int      archive_stream [$];
    int      stream_len;
    record_t expected_records [$];
    int      mismatch_count;
    int      bytes_taken;
    bit      byte_taken;

    // parser model state
    phase_t      parse_state  = PH_MAGIC;
    logic [3:0]  fld_idx      = '0;
    logic [2:0]  digit_idx    = '0;
    logic [31:0] hex_acc      = '0;
    logic [31:0] hdr_field [13];
    logic [31:0] arc_offset   = '0;
    logic [31:0] left_count   = '0;
    bit          trailer_ok   = 1'b1;
    logic [15:0] entry_count  = '0;

    function automatic void restart_header();
        parse_state = PH_MAGIC;
        fld_idx     = '0;
        digit_idx   = '0;
        hex_acc     = '0;
    endfunction

    function automatic void close_entry(input logic [31:0] nxt);
        if (entry_count != 16'hFFFF) entry_count++;
        if (nxt[1:0] != 2'b00) parse_state = PH_DATAPAD;
        else restart_header();
    endfunction

    function automatic void open_data(input logic [31:0] nxt);
        left_count = hdr_field[FLD_FILESIZE];
        if (left_count != 0) parse_state = PH_DATA;
        else close_entry(nxt);
    endfunction

    function automatic void close_name(input logic [31:0] nxt);
        if (nxt[1:0] != 2'b00) parse_state = PH_NAMEPAD;
        else open_data(nxt);
    endfunction

    // advance the parser model by one archive byte; queue the record it yields
    function automatic void parse_archive_byte(input logic [7:0] b);
        record_t     rec;
        logic [31:0] nxt;
        logic [31:0] val;
        logic [31:0] pos;
        int          nib;
        bit          emit;
        if (parse_state == PH_DONE || parse_state == PH_ERROR) return;
        nxt = arc_offset + 32'd1;
        arc_offset = nxt;
        rec = '0;
        rec.file_index = entry_count;
        emit = 1'b0;
        case (parse_state)
            PH_MAGIC: begin
                if (b != MAGIC_TEXT[8*(5 - int'(digit_idx)) +: 8]) begin
                    parse_state = PH_ERROR;
                    rec.kind = KIND_ERROR;
                    emit = 1'b1;
                end else if (digit_idx == MAGIC_LAST) begin
                    parse_state = PH_HEX;
                    digit_idx = '0;
                end else begin
                    digit_idx++;
                end
            end
            PH_HEX: begin
                if (b >= "0" && b <= "9") nib = int'(b - "0");
                else if (b >= "A" && b <= "F") nib = int'(b - "A") + 10;
                else if (b >= "a" && b <= "f") nib = int'(b - "a") + 10;
                else nib = -1;
                if (nib < 0) begin
                    parse_state = PH_ERROR;
                    rec.kind = KIND_ERROR;
                    emit = 1'b1;
                end else begin
                    val = {hex_acc[27:0], 4'(nib)};
                    if (digit_idx != DIGIT_LAST) begin
                        hex_acc = val;
                        digit_idx++;
                    end else begin
                        hdr_field[fld_idx] = val;
                        hex_acc = '0;
                        digit_idx = '0;
                        if (fld_idx != FLD_LAST) begin
                            fld_idx++;
                        end else begin
                            fld_idx = '0;
                            rec.kind         = KIND_HEADER;
                            rec.inode_number = hdr_field[FLD_INO];
                            rec.file_mode    = hdr_field[FLD_MODE];
                            rec.owner_uid    = hdr_field[FLD_UID];
                            rec.owner_gid    = hdr_field[FLD_GID];
                            rec.modify_time  = hdr_field[FLD_MTIME];
                            rec.file_size    = hdr_field[FLD_FILESIZE];
                            rec.name_size    = hdr_field[FLD_NAMESIZE];
                            rec.data_offset  = (nxt + hdr_field[FLD_NAMESIZE] + 32'd3) & ~32'd3;
                            rec.last_of_run  = (hdr_field[FLD_FILESIZE] == 0);
                            emit = 1'b1;
                            trailer_ok = 1'b1;
                            left_count = hdr_field[FLD_NAMESIZE];
                            if (left_count != 0) parse_state = PH_NAME;
                            else close_name(nxt);
                        end
                    end
                end
            end
            PH_NAME: begin
                pos = hdr_field[FLD_NAMESIZE] - left_count;
                if (pos < TRAILER_LEN) begin
                    if (b != END_NAME[8*(10 - int'(pos)) +: 8]) trailer_ok = 1'b0;
                end
                left_count--;
                rec.kind = KIND_NAME;
                rec.byte_value = b;
                emit = 1'b1;
                if (left_count == 0) begin
                    if (trailer_ok && hdr_field[FLD_NAMESIZE] >= TRAILER_LEN) begin
                        parse_state = PH_DONE;
                        rec.kind = KIND_END;
                        rec.byte_value = '0;
                    end else begin
                        rec.last_of_run = 1'b1;
                        close_name(nxt);
                    end
                end
            end
            PH_NAMEPAD: begin
                if (nxt[1:0] == 2'b00) open_data(nxt);
            end
            PH_DATA: begin
                rec.kind = KIND_DATA;
                rec.byte_value = b;
                emit = 1'b1;
                left_count--;
                if (left_count == 0) begin
                    rec.last_of_run = 1'b1;
                    close_entry(nxt);
                end
            end
            default: begin
                if (nxt[1:0] == 2'b00) restart_header();
            end
        endcase
        if (emit) expected_records.push_back(rec);
    endfunction

    function automatic void check_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    // ---------------- archive construction ----------------

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        archive_stream.push_back(int'(b));
        stream_len++;
    endtask

    // padding bytes carry random values; the parser must drop them
    task automatic push_pad();
        while (stream_len % 4 != 0) push_byte(8'($urandom));
    endtask

    task automatic push_entry(input logic [31:0] fld [13], input logic [7:0] nm [$],
                              input int data_len, input int case_sel);
        bit lower;
        fld[FLD_NAMESIZE] = nm.size();
        fld[FLD_FILESIZE] = data_len;
        for (int i = 0; i < 6; i++) push_byte(MAGIC_TEXT[8*(5 - i) +: 8]);
        for (int f = 0; f < 13; f++) begin
            for (int d = 7; d >= 0; d--) begin
                lower = (case_sel == 1) || (case_sel == 2 && $urandom_range(1, 0) == 1);
                push_byte(hex_char(fld[f][4*d +: 4], lower));
            end
        end
        foreach (nm[i]) push_byte(nm[i]);
        push_pad();
        repeat (data_len) push_byte(8'($urandom));
        push_pad();
    endtask

    // ---------------- stimulus, reset and end of run ----------------

    initial begin : stimulus
        logic [31:0] fld [13];
        logic [7:0]  nm [$];
        logic [7:0]  bad;
        int          k;
        int          ending;

        // all-zero header: no name, no data
        foreach (fld[i]) fld[i] = '0;
        nm = {};
        push_entry(fld, nm, 0, 0);
        // all ones in lower case; name is the end marker cut short
        foreach (fld[i]) fld[i] = '1;
        for (k = 0; k < 7; k++) nm.push_back(END_NAME[8*(10 - k) +: 8]);
        nm.push_back(8'h00);
        push_entry(fld, nm, 3, 1);
        archive_stream.push_back(DRAIN_MARK);
        // every hex digit in mixed case; full-length name missing its terminator
        foreach (fld[i]) fld[i] = i[0] ? 32'h89AB_CDEF : 32'h0123_4567;
        nm = {};
        for (k = 0; k < 10; k++) nm.push_back(END_NAME[8*(10 - k) +: 8]);
        nm.push_back("!");
        push_entry(fld, nm, 5, 2);

        ending = $urandom_range(2, 0);
        if (ending == 0) begin
            // end marker, possibly with bytes after the terminator
            foreach (fld[i]) fld[i] = $urandom;
            nm = {};
            for (k = 0; k < 11; k++) nm.push_back(END_NAME[8*(10 - k) +: 8]);
            repeat ($urandom_range(3, 0)) nm.push_back(8'($urandom));
            push_entry(fld, nm, $urandom_range(8, 0), $urandom_range(2, 0));
        end else if (ending == 1) begin
            // bad magic at a random position
            k = $urandom_range(5, 0);
            for (int i = 0; i < k; i++) push_byte(MAGIC_TEXT[8*(5 - i) +: 8]);
            bad = MAGIC_TEXT[8*(5 - k) +: 8] ^ 8'($urandom_range(255, 1));
            push_byte(bad);
        end else begin
            // bad hex digit somewhere in the header fields
            for (int i = 0; i < 6; i++) push_byte(MAGIC_TEXT[8*(5 - i) +: 8]);
            repeat ($urandom_range(103, 0))
                push_byte(hex_char(4'($urandom), $urandom_range(1, 0) == 1));
            case ($urandom_range(7, 0))
                0: bad = 8'h2F;
                1: bad = 8'h3A;
                2: bad = 8'h40;
                3: bad = 8'h47;
                4: bad = 8'h60;
                5: bad = 8'h67;
                6: bad = 8'h00;
                default: bad = 8'hFF;
            endcase
            push_byte(bad);
        end
        // the block must drop everything after the end or error record
        repeat (8) push_byte(8'($urandom));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (archive_stream.size() != 0 || expected_records.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ---------------- sender ----------------

    int gap_left   = 0;
    int burst_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !byte_taken) begin
            // hold the offer until it is taken
        end else if (archive_stream.size() != 0 && archive_stream[0] == DRAIN_MARK) begin
            s_tvalid <= 1'b0;
            if (expected_records.size() == 0) archive_stream.delete(0);
        end else if (archive_stream.size() == 0 || gap_left != 0) begin
            s_tvalid <= 1'b0;
            if (gap_left != 0) gap_left--;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= 8'(archive_stream[0]);
            if (burst_left != 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(48, 1);
                gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
            end
        end
    end

    // ---------------- receiver ----------------

    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int stall_pct      = 0;
    int ready_cycle    = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!long_hold_done && bytes_taken > 300 && expected_records.size() != 0) begin
            // long hold-off: let the record queue fill and stall the input
            m_tready <= 1'b0;
            hold_left = 90;
            long_hold_done = 1'b1;
        end else begin
            ready_cycle++;
            if (ready_cycle % 64 == 0) begin
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // ---------------- record check and input capture ----------------

    always @(posedge aclk) begin
        record_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    $display("%0t: unexpected record, expected none, got kind %0d",
                             $time, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("kind",         32'(want.kind),        32'(m_tuser));
                    check_field("file_index",   32'(want.file_index),  32'(m_tdata[15:0]));
                    check_field("inode_number", want.inode_number,     m_tdata[47:16]);
                    check_field("file_mode",    want.file_mode,        m_tdata[79:48]);
                    check_field("owner_uid",    want.owner_uid,        m_tdata[111:80]);
                    check_field("owner_gid",    want.owner_gid,        m_tdata[143:112]);
                    check_field("modify_time",  want.modify_time,      m_tdata[175:144]);
                    check_field("file_size",    want.file_size,        m_tdata[207:176]);
                    check_field("name_size",    want.name_size,        m_tdata[239:208]);
                    check_field("data_offset",  want.data_offset,      m_tdata[271:240]);
                    check_field("byte_value",   32'(want.byte_value),  32'(m_tdata[279:272]));
                    check_field("last_of_run",  32'(want.last_of_run), 32'(m_tlast));
                end
            end
            byte_taken = s_tvalid && s_tready;
            if (byte_taken) begin
                parse_archive_byte(s_tdata);
                archive_stream.delete(0);
                bytes_taken++;
            end
        end
    end

endmodule

@@ cpio_newc_stream_parser_core.f @@
rtl/cnsp_pkg.sv
rtl/cnsp_front.sv
rtl/cnsp_fifo.sv
rtl/cnsp_back.sv
rtl/cpio_newc_stream_parser_core.sv
sim/tb_cpio_newc_stream_parser_core.sv
